[sv/gtg_pkg.sv]
// Shared types, constants and step functions of the go-to-goal steering controller.
// Depends on nothing; used by gtg_iter and go_to_goal_steering_controller.
package gtg_pkg;

   // Widths of the iteration datapath
   localparam int XW = 28;            // CORDIC x and y
   localparam int ZW = 21;            // CORDIC angle, Q.16 radians
   localparam int SW = 34;            // square-root radicand
   localparam int RW = 17;            // square-root result
   localparam int MW = 21;            // square-root remainder
   localparam int CORDIC_STEPS = 16;
   localparam int ITER_STAGES = 8;

   localparam logic [SW-1:0] FAR_SQ_LIMIT = SW'(41943);
   localparam logic [ZW:0] AIM_LIMIT = (ZW+1)'(13107);
   localparam logic signed [15:0] BOUND_HIGH = 16'sd24576;
   localparam logic signed [ZW-1:0] PI_Q16 = ZW'(205887);
   localparam logic signed [15:0] GOAL_RESET = 16'sd2048;
   localparam logic [15:0] GAIN_RESET = 16'd4096;
   localparam logic [15:0] SPEED_LIMIT_RESET = 16'd4096;

   // Register indexes
   localparam logic [7:0] REG_GAIN = 8'd0;
   localparam logic [7:0] REG_SPEED_LIMIT = 8'd1;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] heading;
   } req_type;

   typedef struct packed {
      logic [15:0] linear_speed;
      logic [15:0] turn_rate;
      logic        target_accepted;
   } rsp_type;

   // One word in flight through the iteration stages
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [MW-1:0]        rem;
      logic [RW-1:0]        root;
      logic [SW-1:0]        rad;
      logic                 mode;
      logic                 acc;
      logic                 far;
      logic signed [15:0]   heading;
   } iter_type;

   function automatic logic signed [ZW-1:0] atan_q16(input int i);
      logic signed [ZW-1:0] a;
      case (i)
         0: a = ZW'(51472);
         1: a = ZW'(30386);
         2: a = ZW'(16055);
         3: a = ZW'(8150);
         4: a = ZW'(4091);
         5: a = ZW'(2047);
         6: a = ZW'(1024);
         7: a = ZW'(512);
         8: a = ZW'(256);
         9: a = ZW'(128);
         10: a = ZW'(64);
         11: a = ZW'(32);
         12: a = ZW'(16);
         13: a = ZW'(8);
         14: a = ZW'(4);
         15: a = ZW'(2);
         default: a = '0;
      endcase
      return a;
   endfunction

   // One vectoring rotation; shifts floor
   function automatic iter_type cordic_step(input iter_type s, input int i);
      iter_type o;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      o = s;
      xs = s.x >>> i;
      ys = s.y >>> i;
      if (!s.y[XW-1]) begin
         o.x = s.x + ys;
         o.y = s.y - xs;
         o.z = s.z + atan_q16(i);
      end else begin
         o.x = s.x - ys;
         o.y = s.y + xs;
         o.z = s.z - atan_q16(i);
      end
      return o;
   endfunction

   // One restoring square-root digit
   function automatic iter_type sqrt_step(input iter_type s);
      iter_type o;
      logic [MW-1:0] r;
      logic [RW+1:0] trial;
      o = s;
      r = {s.rem[MW-3:0], s.rad[SW-1:SW-2]};
      trial = {s.root, 2'b01};
      if (r >= MW'(trial)) begin
         o.rem = r - MW'(trial);
         o.root = {s.root[RW-2:0], 1'b1};
      end else begin
         o.rem = r;
         o.root = {s.root[RW-2:0], 1'b0};
      end
      o.rad = {s.rad[SW-3:0], 2'b00};
      return o;
   endfunction

endpackage

[sv/gtg_iter.sv]
// Iteration pipeline: CORDIC bearing and integer square root, two digits per stage, three in the first.
// Depends on gtg_pkg.
module gtg_iter (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  gtg_pkg::iter_type in_data,
   output logic             out_valid,
   output gtg_pkg::iter_type out_data
);

   localparam int NS = gtg_pkg::ITER_STAGES;

   gtg_pkg::iter_type stage_ff [NS];
   gtg_pkg::iter_type stage_in [NS];
   logic              valid_ff [NS];

   for (genvar j = 0; j < NS; j++) begin : g_stage
      // first stage takes three root digits, the rest two
      localparam int SQ_N = (j == 0) ? 3 : 2;

      always_comb begin
         gtg_pkg::iter_type st;
         st = (j == 0) ? in_data : stage_ff[(j == 0) ? 0 : j-1];
         for (int k = 0; k < 2; k++) begin
            st = gtg_pkg::cordic_step(st, 2*j + k);
         end
         for (int k = 0; k < 3; k++) begin
            if (k < SQ_N) begin
               st = gtg_pkg::sqrt_step(st);
            end
         end
         stage_in[j] = st;
      end

      // advance payload with the pipe
      always_ff @(posedge clock) begin
         if (adv) begin
            stage_ff[j] <= stage_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= (j == 0) ? in_valid : valid_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_data  = stage_ff[NS-1];

endmodule

[sv/go_to_goal_steering_controller.sv]
// Turn-then-drive go-to-goal steering controller, top level.
// Depends on gtg_pkg and gtg_iter.
//
// Usage:
//  req_ channel: one word per pose sample (mode 0) or target request (mode 1).
//  rsp_ channel: exactly one word per request word, in order.
//  csr_ channel: register writes (gain, speed limit); always ready; write only
//  while no word is in flight.
// A target request updates the goal at the edge it is accepted, so the very
// next pose word already measures against the new goal.
// Throughput: one word per cycle while the receiver does not stall; the pipeline
// is 13 register stages deep, set by the 16-step CORDIC and 17-digit square root
// run two steps and two digits a stage (three digits in the first).
// When the receiver stalls with a word waiting, the whole pipeline holds and
// req_ready drops; nothing is lost or repeated.
// Reset clears all valid bits, restores gain and the speed limit to 1.0 and the
// goal to (1.0, 1.0).
module go_to_goal_steering_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gtg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gtg_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [15:0]      csr_data
);

   localparam int XW = gtg_pkg::XW;
   localparam int ZW = gtg_pkg::ZW;
   localparam int SW = gtg_pkg::SW;
   localparam int RW = gtg_pkg::RW;

   logic adv;
   logic req_fire;

   logic [15:0]        gain_ff;
   logic [15:0]        speed_limit_ff;
   logic signed [15:0] goal_x_ff;
   logic signed [15:0] goal_y_ff;

   // stage 0: offsets
   logic               v0_ff;
   logic               mode0_ff, acc0_ff;
   logic signed [16:0] dx0_ff, dy0_ff;
   logic signed [15:0] head0_ff;
   logic               acc_in;
   logic signed [16:0] dx_in, dy_in;

   // stage 1: squares and CORDIC start
   logic               v1_ff;
   logic [31:0]        dxsq1_ff, dysq1_ff;
   gtg_pkg::iter_type  it1_ff, it1_in;
   logic [15:0]        adx, ady;

   // stage 2: sum of squares
   logic               v2_ff;
   gtg_pkg::iter_type  it2_ff, it2_in;
   logic [SW-1:0]      sq_sum;

   logic               itv_out;
   gtg_pkg::iter_type  it_out;

   // stage 11: error and speed product
   logic               v11_ff;
   logic               mode11_ff, acc11_ff, far11_ff, bad11_ff;
   logic [15:0]        turn11_ff, turn11_in;
   logic [RW+15:0]     prod11_ff;
   logic               bad_in;
   logic signed [ZW:0] err;
   logic [ZW:0]        mag;
   logic [ZW-2:0]      turn_wide;

   logic               rsp_valid_ff;
   gtg_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic [RW+4:0]      lin_wide;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff        <= gtg_pkg::GAIN_RESET;
         speed_limit_ff <= gtg_pkg::SPEED_LIMIT_RESET;
      end else if (csr_valid) begin
         if (csr_index == gtg_pkg::REG_GAIN) begin
            gain_ff <= csr_data;
         end else if (csr_index == gtg_pkg::REG_SPEED_LIMIT) begin
            speed_limit_ff <= csr_data;
         end
      end
   end

   // target bound test and goal update at accept
   assign acc_in = req_data.mode &&
                   (req_data.pos_x > 16'sd0) && (req_data.pos_x < gtg_pkg::BOUND_HIGH) &&
                   (req_data.pos_y > 16'sd0) && (req_data.pos_y < gtg_pkg::BOUND_HIGH);

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= gtg_pkg::GOAL_RESET;
         goal_y_ff <= gtg_pkg::GOAL_RESET;
      end else if (req_fire && acc_in) begin
         goal_x_ff <= req_data.pos_x;
         goal_y_ff <= req_data.pos_y;
      end
   end

   assign dx_in = 17'(goal_x_ff) - 17'(req_data.pos_x);
   assign dy_in = 17'(goal_y_ff) - 17'(req_data.pos_y);

   always_ff @(posedge clock) begin
      if (adv) begin
         mode0_ff <= req_data.mode;
         acc0_ff  <= acc_in;
         dx0_ff   <= dx_in;
         dy0_ff   <= dy_in;
         head0_ff <= req_data.heading;
      end
   end

   // squares of magnitudes; fold left half-plane onto the right
   assign adx = dx0_ff[16] ? 16'(-dx0_ff) : dx0_ff[15:0];
   assign ady = dy0_ff[16] ? 16'(-dy0_ff) : dy0_ff[15:0];

   always_comb begin
      it1_in = '0;
      it1_in.mode = mode0_ff;
      it1_in.acc = acc0_ff;
      it1_in.heading = head0_ff;
      if (dx0_ff[16]) begin
         it1_in.x = -(XW'(dx0_ff) <<< 8);
         it1_in.y = -(XW'(dy0_ff) <<< 8);
         it1_in.z = dy0_ff[16] ? -gtg_pkg::PI_Q16 : gtg_pkg::PI_Q16;
      end else begin
         it1_in.x = XW'(dx0_ff) <<< 8;
         it1_in.y = XW'(dy0_ff) <<< 8;
         it1_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dxsq1_ff <= adx * adx;
         dysq1_ff <= ady * ady;
         it1_ff   <= it1_in;
      end
   end

   // sum of squares, far test, root start
   assign sq_sum = SW'(dxsq1_ff) + SW'(dysq1_ff);

   always_comb begin
      it2_in = it1_ff;
      it2_in.rad = sq_sum;
      it2_in.rem = '0;
      it2_in.root = '0;
      it2_in.far = sq_sum > gtg_pkg::FAR_SQ_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it2_ff <= it2_in;
      end
   end

   gtg_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .in_data   (it2_ff),
      .out_valid (itv_out),
      .out_data  (it_out)
   );

   // bearing error, turn rate, speed product
   assign err = (ZW+1)'(it_out.z) - ((ZW+1)'(it_out.heading) <<< 3);
   assign mag = err[ZW] ? (ZW+1)'(-err) : err;
   assign bad_in = mag > gtg_pkg::AIM_LIMIT;
   assign turn_wide = (ZW-1)'((mag + (ZW+1)'(4)) >> 3);
   assign turn11_in = (turn_wide > (ZW-1)'(16'hFFFF)) ? 16'hFFFF : turn_wide[15:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         mode11_ff <= it_out.mode;
         acc11_ff  <= it_out.acc;
         far11_ff  <= it_out.far;
         bad11_ff  <= bad_in;
         turn11_ff <= turn11_in;
         prod11_ff <= gain_ff * it_out.root;
      end
   end

   // clamp and select the result word
   assign lin_wide = prod11_ff[RW+15:11];

   always_comb begin
      rsp_data_in = '0;
      if (mode11_ff) begin
         rsp_data_in.target_accepted = acc11_ff;
      end else if (far11_ff) begin
         if (bad11_ff) begin
            rsp_data_in.turn_rate = turn11_ff;
         end else if (lin_wide > (RW+5)'(speed_limit_ff)) begin
            rsp_data_in.linear_speed = speed_limit_ff;
         end else begin
            rsp_data_in.linear_speed = lin_wide[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v11_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= req_valid;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v11_ff       <= itv_out;
         rsp_valid_ff <= v11_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.linear_speed == 16'd0 || rsp_data.turn_rate == 16'd0))
      else $error("speed and turn both nonzero");

   a_target_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.target_accepted) |->
         (rsp_data.linear_speed == 16'd0 && rsp_data.turn_rate == 16'd0))
      else $error("target reply carries motion");

   a_goal_bounds: assert property (@(posedge clock) disable iff (reset)
      (goal_x_ff > 16'sd0 && goal_x_ff < gtg_pkg::BOUND_HIGH &&
       goal_y_ff > 16'sd0 && goal_y_ff < gtg_pkg::BOUND_HIGH))
      else $error("goal out of bounds");

   a_speed_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.linear_speed <= speed_limit_ff))
      else $error("speed above clamp");

endmodule
